### src/fmprt_pkg.sv
// ----------------------------------------------------------------------------
// fmprt_pkg: shared types and constants
// Rule record, action codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package fmprt_pkg;

	localparam int unsigned MAX_RULES_DEF = 64;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_CHECK  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_FILTER_EN = 2'd0,
		REG_POL_IN    = 2'd1,
		REG_POL_OUT   = 2'd2,
		REG_POL_FWD   = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_SCAN = 2'd1,
		SEQ_DONE = 2'd2
	} seq_state_t;

	// One stored rule.
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [1:0]  protocol;
		logic [1:0]  direction;
		logic [1:0]  verdict;
		logic        active;
		logic [31:0] hits;
	} rule_t;

	// The packet being scanned down the chain.
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [1:0]  protocol;
		logic [1:0]  direction;
	} pkt_t;

	// Control from the sequencer to every cell.
	typedef struct packed {
		logic load;     // append rule at the tail
		logic shift;    // remove: cells at or above index take their upper neighbor
		logic bump;     // increment hit counter at hit position
		logic clear;    // drop the match token (start of every word)
	} cell_ctl_t;

	function automatic logic rule_hit(rule_t r, pkt_t p);
		return r.active
			&& (r.protocol == 2'd0 || r.protocol == p.protocol)
			&& (r.direction == p.direction)
			&& (r.sport == 16'd0 || r.sport == p.sport)
			&& (r.dport == 16'd0 || r.dport == p.dport)
			&& (r.src_addr == 32'd0 || r.src_addr == p.src_addr)
			&& (r.dst_addr == 32'd0 || r.dst_addr == p.dst_addr);
	endfunction

endpackage

### src/fmprt_if.sv
// ----------------------------------------------------------------------------
// fmprt_if: valid/ready channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface fmprt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [5:0]  rule_index;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] sport;
	logic [15:0] dport;
	logic [1:0]  protocol;
	logic [1:0]  direction;
	logic [1:0]  rule_verdict;
	logic        rule_active;
	modport source (output valid, action, rule_index, src_addr, dst_addr, sport,
		dport, protocol, direction, rule_verdict, rule_active, input ready);
	modport sink (input valid, action, rule_index, src_addr, dst_addr, sport,
		dport, protocol, direction, rule_verdict, rule_active, output ready);
endinterface

interface fmprt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  verdict;
	logic        matched;
	logic [5:0]  hit_index;
	logic [31:0] hit_count;
	modport source (output valid, status, verdict, matched, hit_index, hit_count,
		input ready);
	modport sink (input valid, status, verdict, matched, hit_index, hit_count,
		output ready);
endinterface

interface fmprt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/fmprt_cell.sv
// ----------------------------------------------------------------------------
// fmprt_cell: one rule slot of the chain
// Holds one rule, compares it against the packet and passes the first-hit
// token to the next cell.
// ----------------------------------------------------------------------------
module fmprt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  fmprt_pkg::cell_ctl_t ctl,
	input  logic              is_tail,     // this slot is rule_total
	input  logic              at_or_above, // this slot >= remove index
	input  logic              in_range,    // this slot < rule_total
	input  fmprt_pkg::rule_t  new_rule,
	input  fmprt_pkg::rule_t  upper_rule,
	input  fmprt_pkg::pkt_t   pkt,
	input  logic              step_here,   // scan pointer is at this slot
	input  logic              hit_prev,    // an earlier slot already matched
	output fmprt_pkg::rule_t  rule,
	output logic              hit_out,     // token: first match at or before here
	output logic              hit_here_q
);
	import fmprt_pkg::*;

	rule_t rule_q;
	logic  hit_tok_q;
	logic  match;

	assign rule = rule_q;
	assign match = in_range && rule_hit(rule_q, pkt);
	assign hit_out = hit_prev || hit_tok_q;

	// The new rule arrives with its hit counter already cleared.
	always_ff @(posedge clk) begin
		if (ctl.load && is_tail) begin
			rule_q <= new_rule;
		end else if (ctl.shift && at_or_above) begin
			rule_q <= upper_rule;
		end else if (ctl.bump && hit_here_q) begin
			rule_q.hits <= rule_q.hits + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_tok_q  <= 1'b0;
			hit_here_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_tok_q  <= 1'b0;
			hit_here_q <= 1'b0;
		end else if (step_here && !hit_prev && match) begin
			hit_tok_q  <= 1'b1;
			hit_here_q <= 1'b1;
		end
	end
endmodule

### src/first_match_packet_rule_table.sv
// ----------------------------------------------------------------------------
// first_match_packet_rule_table: ordered first-match packet filter
// A chain of rule cells driven by a small sequencer.
// ----------------------------------------------------------------------------
// The table is a row of MAX_RULES identical cells, one rule each. An add
// word loads the tail cell and a remove word makes every cell from the
// removed position up take its upper neighbor all at once; both pass
// through the SCAN and DONE states before their result is registered, as
// does a check while filtering is disabled. A check word walks a first-hit
// token along the chain, one cell per cycle, and the walk stops in the
// cycle after it reaches the first matching cell, whose counter is bumped.
// A check that matches nothing walks all rule_total cells (at most
// MAX_RULES). The result sits in an output register, and one word is in
// work at a time: a new word is taken no earlier than the cycle after the
// result has been accepted. Configuration writes are always taken and
// should only be made while no word is in work. There is no clearing pass
// after reset.
module first_match_packet_rule_table #(
	parameter int unsigned MAX_RULES = fmprt_pkg::MAX_RULES_DEF
) (
	input logic clk,
	input logic arst_n,
	fmprt_in_if.sink     in_ch,
	fmprt_out_if.source  out_ch,
	fmprt_cfg_if.sink    cfg
);
	import fmprt_pkg::*;

	localparam int unsigned IW = $clog2(MAX_RULES);
	localparam int unsigned CW = $clog2(MAX_RULES + 1);

	// Configuration registers. Writes are always taken.
	logic       filter_en_q;
	logic [1:0] pol_in_q, pol_out_q, pol_fwd_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= 1'b1;
			pol_in_q    <= 2'd1;
			pol_out_q   <= 2'd0;
			pol_fwd_q   <= 2'd1;
		end else if (cfg.valid) begin
			case (reg_index_t'(cfg.index))
				REG_FILTER_EN: filter_en_q <= cfg.data[0];
				REG_POL_IN:    pol_in_q    <= cfg.data[1:0];
				REG_POL_OUT:   pol_out_q   <= cfg.data[1:0];
				REG_POL_FWD:   pol_fwd_q   <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	// Captured item.
	action_t    act_q;
	logic [5:0] idx_q;
	pkt_t       pkt_q;
	rule_t      new_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] ptr_q;

	seq_state_t state_q, state_d;
	cell_ctl_t  ctl;
	logic       out_valid_q;

	rule_t cell_rule [MAX_RULES];
	logic  hit_chain [MAX_RULES+1];
	logic  hit_here  [MAX_RULES];

	logic take;
	logic scan_end;
	logic idx_ok;
	logic ctl_done_load_q, ctl_done_shift_q;

	assign in_ch.ready = (state_q == SEQ_IDLE) && !out_valid_q;
	assign take = in_ch.valid && in_ch.ready;
	assign idx_ok = {{(CW > 6 ? CW - 6 : 0){1'b0}}, idx_q} < total_q;
	assign scan_end = hit_chain[MAX_RULES] || (ptr_q >= total_q) || !filter_en_q;

	assign hit_chain[0] = 1'b0;

	generate
		for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
			rule_t up;
			if (g == MAX_RULES - 1) begin : g_last
				assign up = cell_rule[g];
			end else begin : g_mid
				assign up = cell_rule[g+1];
			end
			fmprt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.is_tail    (total_q == CW'(g)),
				.at_or_above(CW'(g) >= CW'(idx_q)),
				.in_range   (CW'(g) < total_q),
				.new_rule   (new_q),
				.upper_rule (up),
				.pkt        (pkt_q),
				.step_here  (state_q == SEQ_SCAN && ptr_q == CW'(g)),
				.hit_prev   (hit_chain[g]),
				.rule       (cell_rule[g]),
				.hit_out    (hit_chain[g+1]),
				.hit_here_q (hit_here[g])
			);
		end
	endgenerate

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: if (take) state_d = SEQ_SCAN;
			SEQ_SCAN: if (act_q != ACT_CHECK || scan_end) state_d = SEQ_DONE;
			SEQ_DONE: state_d = SEQ_IDLE;
			default:  state_d = SEQ_IDLE;
		endcase
	end

	// Cell controls.
	always_comb begin
		ctl = '0;
		case (state_q)
			SEQ_IDLE: ctl.clear = take;
			SEQ_SCAN: begin
				ctl.load  = (act_q == ACT_ADD) && (total_q < CW'(MAX_RULES));
				ctl.shift = (act_q == ACT_REMOVE) && idx_ok;
			end
			SEQ_DONE: ctl.bump = (act_q == ACT_CHECK) && filter_en_q;
			default: ;
		endcase
	end

	// Hit position encoder (one-hot token cells).
	logic [IW-1:0] hit_pos;
	always_comb begin
		hit_pos = '0;
		for (int k = 0; k < MAX_RULES; k++) begin
			if (hit_here[k]) hit_pos = IW'(k);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_q <= action_t'(in_ch.action);
			idx_q <= in_ch.rule_index;
			pkt_q <= '{in_ch.src_addr, in_ch.dst_addr, in_ch.sport, in_ch.dport,
				in_ch.protocol, in_ch.direction};
			new_q <= '{in_ch.src_addr, in_ch.dst_addr, in_ch.sport, in_ch.dport,
				in_ch.protocol, in_ch.direction, in_ch.rule_verdict, in_ch.rule_active,
				32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			total_q <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (take) ptr_q <= '0;
			else if (state_q == SEQ_SCAN && !scan_end) ptr_q <= ptr_q + CW'(1);
			if (ctl.load) total_q <= total_q + CW'(1);
			else if (ctl.shift) total_q <= total_q - CW'(1);
		end
	end

	// Result register.
	logic [1:0]  r_status_q, r_verdict_q;
	logic        r_matched_q;
	logic [5:0]  r_idx_q;
	logic [31:0] r_count_q;
	logic        any_hit;
	rule_t       hr;

	assign any_hit = hit_chain[MAX_RULES];
	assign hr = cell_rule[hit_pos];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == SEQ_DONE) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_DONE) begin
			r_status_q  <= ST_OK;
			r_verdict_q <= 2'd0;
			r_matched_q <= 1'b0;
			r_idx_q     <= '0;
			r_count_q   <= '0;
			case (act_q)
				ACT_ADD: if (!ctl_done_load_q) r_status_q <= ST_FULL;
				ACT_REMOVE: if (!ctl_done_shift_q) r_status_q <= ST_RANGE;
				ACT_CHECK: begin
					if (filter_en_q) begin
						if (any_hit) begin
							r_verdict_q <= hr.verdict;
							r_matched_q <= 1'b1;
							r_idx_q     <= 6'(hit_pos);
							r_count_q   <= hr.hits + 32'd1;
						end else if (pkt_q.direction == 2'd0) begin
							r_verdict_q <= pol_in_q;
						end else if (pkt_q.direction == 2'd1) begin
							r_verdict_q <= pol_out_q;
						end else begin
							r_verdict_q <= pol_fwd_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Remember whether the add or remove went through.
	always_ff @(posedge clk) begin
		if (state_q == SEQ_SCAN) begin
			ctl_done_load_q  <= ctl.load;
			ctl_done_shift_q <= ctl.shift;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.status    = r_status_q;
	assign out_ch.verdict   = r_verdict_q;
	assign out_ch.matched   = r_matched_q;
	assign out_ch.hit_index = r_idx_q;
	assign out_ch.hit_count = r_count_q;
endmodule

### sim/fmprt_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmprt_tb_pkg: test-side rule table predictor
// Mirrors the ordered rule table and its registers to predict each result.
// ----------------------------------------------------------------------------
package fmprt_tb_pkg;
	import fmprt_pkg::*;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  rule_index;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [1:0]  protocol;
		logic [1:0]  direction;
		logic [1:0]  rule_verdict;
		logic        rule_active;
	} pkt_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  verdict;
		logic        matched;
		logic [5:0]  hit_index;
		logic [31:0] hit_count;
	} verdict_word_t;

	localparam int unsigned TABLE_DEPTH = MAX_RULES_DEF;

	rule_t       shadow_rules [TABLE_DEPTH];
	int unsigned shadow_total;
	logic        shadow_enable;
	logic [1:0]  shadow_pol_in, shadow_pol_out, shadow_pol_fwd;

	function automatic void shadow_reset();
		shadow_total   = 0;
		shadow_enable  = 1'b1;
		shadow_pol_in  = 2'd1;
		shadow_pol_out = 2'd0;
		shadow_pol_fwd = 2'd1;
	endfunction

	function automatic void shadow_write_reg(reg_index_t idx, logic [31:0] value);
		case (idx)
			REG_FILTER_EN: shadow_enable  = value[0];
			REG_POL_IN:    shadow_pol_in  = value[1:0];
			REG_POL_OUT:   shadow_pol_out = value[1:0];
			default:       shadow_pol_fwd = value[1:0];
		endcase
	endfunction

	// Applies one word to the shadow table and returns the result it causes.
	function automatic verdict_word_t classify(pkt_word_t w);
		verdict_word_t r;
		rule_t         nr;
		logic          hit;
		r = '0;
		case (action_t'(w.action))
			ACT_ADD: begin
				if (shadow_total >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					nr.src_addr  = w.src_addr;
					nr.dst_addr  = w.dst_addr;
					nr.sport     = w.sport;
					nr.dport     = w.dport;
					nr.protocol  = w.protocol;
					nr.direction = w.direction;
					nr.verdict   = w.rule_verdict;
					nr.active    = w.rule_active;
					nr.hits      = '0;
					shadow_rules[shadow_total] = nr;
					shadow_total++;
				end
			end
			ACT_REMOVE: begin
				if (w.rule_index >= shadow_total) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = w.rule_index; i + 1 < shadow_total; i++)
						shadow_rules[i] = shadow_rules[i + 1];
					shadow_total--;
				end
			end
			ACT_CHECK: begin
				if (shadow_enable) begin
					for (int i = 0; i < shadow_total; i++) begin
						nr = shadow_rules[i];
						hit = nr.active
							&& (nr.protocol == 2'd0 || nr.protocol == w.protocol)
							&& (nr.direction == w.direction)
							&& (nr.sport == 16'd0 || nr.sport == w.sport)
							&& (nr.dport == 16'd0 || nr.dport == w.dport)
							&& (nr.src_addr == 32'd0 || nr.src_addr == w.src_addr)
							&& (nr.dst_addr == 32'd0 || nr.dst_addr == w.dst_addr);
						if (hit && !r.matched) begin
							shadow_rules[i].hits = nr.hits + 32'd1;
							r.verdict   = nr.verdict;
							r.matched   = 1'b1;
							r.hit_index = i[5:0];
							r.hit_count = nr.hits + 32'd1;
						end
					end
					if (!r.matched)
						r.verdict = (w.direction == 2'd0) ? shadow_pol_in :
							(w.direction == 2'd1) ? shadow_pol_out : shadow_pol_fwd;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

endpackage

### sim/first_match_packet_rule_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_match_packet_rule_table_tb: self-checking bench for the rule table
// Drives add, remove and check words with random bursts and stalls, and
// compares every result word against a shadow table kept on the test side.
// ----------------------------------------------------------------------------
module first_match_packet_rule_table_tb;
	import fmprt_pkg::*;
	import fmprt_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RANDOM_WORDS   = 768;

	logic clk;
	logic arst_n;

	fmprt_in_if  in_ch();
	fmprt_out_if out_ch();
	fmprt_cfg_if cfg();

	first_match_packet_rule_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	// Expected result words in issue order, with an optional hand-typed value
	// used for the directed rows where the answer is obvious.
	verdict_word_t pending_verdicts[$];
	int            mismatch_count;
	int            idle_cycles;
	bit            timed_out;
	bit            sink_stall_mode;

	typedef struct {
		pkt_word_t     w;
		bit            typed;
		verdict_word_t want;
	} directed_row_t;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// The watchdog counts cycles in which no channel moves a word.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Mismatches found");
			$finish;
		end
	end

	// The result side: compare each accepted word with the oldest expectation.
	always @(posedge clk) begin
		verdict_word_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.status, out_ch.verdict, out_ch.matched, out_ch.hit_index,
				out_ch.hit_count};
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h",
					$time, got);
				mismatch_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got.status !== want.status)
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, got.status);
				if (got.verdict !== want.verdict)
					$display("%0t: verdict expected %0d actual %0d", $time,
						want.verdict, got.verdict);
				if (got.matched !== want.matched)
					$display("%0t: matched expected %0d actual %0d", $time,
						want.matched, got.matched);
				if (got.hit_index !== want.hit_index)
					$display("%0t: hit_index expected %0d actual %0d", $time,
						want.hit_index, got.hit_index);
				if (got.hit_count !== want.hit_count)
					$display("%0t: hit_count expected %0d actual %0d", $time,
						want.hit_count, got.hit_count);
				if (got !== want)
					mismatch_count++;
			end
		end
	end

	// The receiver stalls on its own pattern: sometimes a long run of ready,
	// sometimes a random duty of ready and stall.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				sink_stall_mode = ~sink_stall_mode;
			if (sink_stall_mode)
				out_ch.ready <= ($urandom_range(0, 3) != 0);
			else
				out_ch.ready <= 1'b1;
		end
	end

	// Sends one word and logs its expectation once the handshake completes.
	// A word whose answer was typed into the table is checked against that
	// value as well as against the shadow table.
	task automatic send_word(pkt_word_t w, bit typed, verdict_word_t typed_want);
		verdict_word_t predicted;
		in_ch.valid        <= 1'b1;
		in_ch.action       <= w.action;
		in_ch.rule_index   <= w.rule_index;
		in_ch.src_addr     <= w.src_addr;
		in_ch.dst_addr     <= w.dst_addr;
		in_ch.sport        <= w.sport;
		in_ch.dport        <= w.dport;
		in_ch.protocol     <= w.protocol;
		in_ch.direction    <= w.direction;
		in_ch.rule_verdict <= w.rule_verdict;
		in_ch.rule_active  <= w.rule_active;
		do @(posedge clk); while (!in_ch.ready);
		predicted = classify(w);
		if (typed && predicted !== typed_want) begin
			$display("%0t: table row expected %h, shadow table gives %h", $time,
				typed_want, predicted);
			mismatch_count++;
		end
		pending_verdicts.push_back(predicted);
		@(negedge clk);
	endtask

	// Drops valid for a random gap; zero keeps the burst going.
	task automatic sender_gap(int unsigned len);
		if (len > 0) begin
			in_ch.valid <= 1'b0;
			repeat (len) @(negedge clk);
		end
	endtask

	// Stops sending, waits for every expected result, then idles a while.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (MAX_RULES_DEF + 8) @(negedge clk);
	endtask

	// Back-to-back writes keep valid high; the caller drops it afterwards.
	task automatic write_reg(reg_index_t idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		shadow_write_reg(idx, value);
		@(negedge clk);
	endtask

	// Random packet fields drawn from a small pool so that checks hit rules.
	function automatic logic [31:0] pick_addr();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'hC0A8_0000 | $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'd80 + $urandom_range(0, 2);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic pkt_word_t random_word();
		pkt_word_t w;
		int unsigned roll;
		w.rule_index   = $urandom_range(0, 63);
		w.src_addr     = pick_addr();
		w.dst_addr     = pick_addr();
		w.sport        = pick_port();
		w.dport        = pick_port();
		w.protocol     = $urandom_range(0, 3);
		w.direction    = $urandom_range(0, 3);
		w.rule_verdict = $urandom_range(0, 3);
		w.rule_active  = ($urandom_range(0, 4) != 0);
		roll = $urandom_range(0, 99);
		// Mostly checks, with enough adds to fill the table and removes to
		// shuffle it; the occasional unused action code is noise.
		if (roll < 30)
			w.action = ACT_ADD;
		else if (roll < 42)
			w.action = ACT_REMOVE;
		else if (roll < 97)
			w.action = ACT_CHECK;
		else
			w.action = ACT_NONE;
		if (w.action == ACT_REMOVE && shadow_total > 0 && $urandom_range(0, 3) != 0)
			w.rule_index = $urandom_range(0, shadow_total - 1);
		return w;
	endfunction

	// Builds a directed row; a typed answer is given only when obvious.
	function automatic directed_row_t row(action_t act, logic [5:0] idx,
			logic [31:0] sa, logic [31:0] da, logic [15:0] sp, logic [15:0] dp,
			logic [1:0] proto, logic [1:0] dir, logic [1:0] rv, logic ra,
			bit typed, verdict_word_t want);
		directed_row_t r;
		r.w = {act, idx, sa, da, sp, dp, proto, dir, rv, ra};
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	initial begin
		directed_row_t table_rows[$];
		verdict_word_t ok_word;
		pkt_word_t     w;
		int unsigned   phase;

		arst_n          = 1'b0;
		idle_cycles     = 0;
		timed_out       = 1'b0;
		mismatch_count  = 0;
		sink_stall_mode = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.action    = ACT_NONE;
		in_ch.rule_index = '0;
		in_ch.src_addr  = '0;
		in_ch.dst_addr  = '0;
		in_ch.sport     = '0;
		in_ch.dport     = '0;
		in_ch.protocol  = '0;
		in_ch.direction = '0;
		in_ch.rule_verdict = '0;
		in_ch.rule_active  = 1'b0;
		out_ch.ready    = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_FILTER_EN;
		cfg.data        = '0;
		shadow_reset();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		ok_word = '0;
		// After reset the table is empty: checks fall to the default policies
		// (inbound 1, outbound 0, forward 1) and removes are refused.
		table_rows.push_back(row(ACT_CHECK, 0, 1, 2, 3, 4, 1, 0, 0, 0, 1,
			'{ST_OK, 2'd1, 1'b0, 6'd0, 32'd0}));
		table_rows.push_back(row(ACT_CHECK, 0, 1, 2, 3, 4, 2, 1, 0, 0, 1,
			'{ST_OK, 2'd0, 1'b0, 6'd0, 32'd0}));
		table_rows.push_back(row(ACT_CHECK, 0, 1, 2, 3, 4, 3, 2, 0, 0, 1,
			'{ST_OK, 2'd1, 1'b0, 6'd0, 32'd0}));
		table_rows.push_back(row(ACT_CHECK, 0, 1, 2, 3, 4, 3, 3, 0, 0, 1,
			'{ST_OK, 2'd1, 1'b0, 6'd0, 32'd0}));
		table_rows.push_back(row(ACT_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			'{ST_RANGE, 2'd0, 1'b0, 6'd0, 32'd0}));
		table_rows.push_back(row(ACT_NONE, 63, '1, '1, '1, '1, 3, 3, 3, 1, 1, ok_word));
		// A rule with direction 2 and every other field at its top value, then an
		// inactive one, then a catch-all wildcard rule for direction 3.
		table_rows.push_back(row(ACT_ADD, 63, '1, '1, '1, '1, 3, 2, 3, 1, 1, ok_word));
		table_rows.push_back(row(ACT_ADD, 0, 0, 0, 0, 0, 0, 0, 2, 0, 1, ok_word));
		table_rows.push_back(row(ACT_ADD, 0, 0, 0, 0, 0, 0, 3, 2, 1, 1, ok_word));
		table_rows.push_back(row(ACT_CHECK, 0, '1, '1, '1, '1, 3, 2, 0, 0, 1,
			'{ST_OK, 2'd3, 1'b1, 6'd0, 32'd1}));
		table_rows.push_back(row(ACT_CHECK, 0, '1, '1, '1, '1, 3, 2, 0, 0, 0, ok_word));
		// Packet protocol 0 against a protocol-specific rule, then direction 3.
		table_rows.push_back(row(ACT_CHECK, 0, '1, '1, '1, '1, 0, 2, 0, 0, 0, ok_word));
		table_rows.push_back(row(ACT_CHECK, 0, 5, 6, 7, 8, 0, 3, 0, 0, 0, ok_word));
		table_rows.push_back(row(ACT_CHECK, 0, 5, 6, 7, 8, 2, 0, 0, 0, 0, ok_word));
		table_rows.push_back(row(ACT_REMOVE, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, ok_word));
		table_rows.push_back(row(ACT_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ok_word));
		table_rows.push_back(row(ACT_CHECK, 0, 5, 6, 7, 8, 1, 0, 0, 0, 0, ok_word));
		table_rows.push_back(row(ACT_REMOVE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, ok_word));

		foreach (table_rows[i]) begin
			send_word(table_rows[i].w, table_rows[i].typed, table_rows[i].want);
			sender_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
		end

		// Fill the table to the brim and knock on it once more: that add must
		// be refused as full.
		wait_drained();
		while (shadow_total < TABLE_DEPTH) begin
			w = random_word();
			w.action = ACT_ADD;
			send_word(w, 1'b0, ok_word);
		end
		w = random_word();
		w.action = ACT_ADD;
		send_word(w, 1'b1, '{ST_FULL, 2'd0, 1'b0, 6'd0, 32'd0});
		w.action = ACT_CHECK;
		send_word(w, 1'b0, ok_word);
		w.action = ACT_REMOVE;
		w.rule_index = 63;
		send_word(w, 1'b0, ok_word);

		// Random part, split into phases; between phases the registers move
		// through their extremes and random values while the block is idle.
		for (phase = 0; phase < 6; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					write_reg(REG_FILTER_EN, 32'd0);
					write_reg(REG_POL_IN, 32'd0);
					write_reg(REG_POL_OUT, 32'd3);
					write_reg(REG_POL_FWD, 32'd0);
				end
				1: begin
					write_reg(REG_FILTER_EN, 32'd1);
					write_reg(REG_POL_IN, 32'd3);
					write_reg(REG_POL_OUT, 32'd2);
					write_reg(REG_POL_FWD, 32'd3);
				end
				default: begin
					write_reg(REG_FILTER_EN, ($urandom_range(0, 4) != 0));
					write_reg(REG_POL_IN, $urandom);
					write_reg(REG_POL_OUT, $urandom);
					write_reg(REG_POL_FWD, $urandom);
				end
			endcase
			cfg.valid <= 1'b0;
			@(negedge clk);
			for (int n = 0; n < RANDOM_WORDS / 6; n++) begin
				send_word(random_word(), 1'b0, ok_word);
				// Bursts of random length with random gaps in between.
				if ($urandom_range(0, 5) == 0)
					sender_gap($urandom_range(1, 12));
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
